// File: rtl/normalized_polynomial_lsq_fit_unit_defines.svh
// Assertion macros for the checker file of the polynomial fit unit.
// Depends on nothing; included by the checker module.
`ifndef NORMALIZED_POLYNOMIAL_LSQ_FIT_UNIT_DEFINES_SVH
`define NORMALIZED_POLYNOMIAL_LSQ_FIT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("polynomial fit unit check failed");

// Consequent must hold in the cycle after the antecedent.
`define NPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("polynomial fit unit check failed");

`endif

// File: rtl/npf_pkg.sv
// Shared types and constants of the normalized polynomial fit unit.
// No dependencies; imported by the fit unit top level, npf_points and npf_muldiv.
`default_nettype none

package npf_pkg;

    // Sums of up to 32 unsigned 16-bit coordinates.
    localparam int SUM_W = 21;

    localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
    localparam logic signed [63:0] SAT_LIM = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q14 = 64'sh0000_0000_0000_4000;
    localparam logic signed [63:0] IMM_ONE = 64'sh0000_0000_0000_0001;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] d;
    } t_md_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] q;
    } t_md_rsp;

    typedef struct packed {
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [15:0]      xmin;
        logic [15:0]      xmax;
    } t_pt_stats;

endpackage

`default_nettype wire

// File: rtl/npf_muldiv.sv
// Shared multiply-divide unit: round(a*b/d), halves away from zero, saturated.
// Uses npf_pkg for the request and response types.
`default_nettype none

module npf_muldiv
    import npf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_md_req i_req,
    output t_md_rsp      o_rsp
);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_MUL  = 5'b00010,
        MD_DIV  = 5'b00100,
        MD_RND  = 5'b01000,
        MD_DONE = 5'b10000
    } t_md_state;

    t_md_state          r_st;
    logic [6:0]         r_cnt;
    logic [63:0]        r_ua, r_ub, r_ud;
    logic               r_neg, r_dz, r_ovf;
    logic [127:0]       r_prod;
    logic [63:0]        r_rem, r_q;
    logic signed [63:0] r_res;

    logic [31:0]  half_a, half_b;
    logic [63:0]  pp;
    logic [1:0]   sh;
    logic [127:0] pp_sh;
    logic [64:0]  rem2;
    logic         ge;
    logic         up;
    logic [64:0]  qs;
    logic         sat;
    logic [63:0]  magn;

    assign half_a = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign half_b = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign pp     = {32'd0, half_a} * {32'd0, half_b};
    assign sh     = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign pp_sh  = {64'd0, pp} << {sh, 5'd0};

    // One restoring step of the 128 by 64 bit division.
    assign rem2 = {r_rem, r_prod[127]};
    assign ge   = rem2 >= {1'b0, r_ud};

    assign up   = r_rem >= (r_ud - r_rem);
    assign qs   = {1'b0, r_q} + {64'd0, up};
    assign sat  = r_ovf || qs[64] || (qs[63:0] > SAT_LIM);
    assign magn = sat ? SAT_LIM : qs[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= MD_IDLE;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_ua   <= i_req.a < 0 ? 64'(-i_req.a) : 64'(i_req.a);
                        r_ub   <= i_req.b < 0 ? 64'(-i_req.b) : 64'(i_req.b);
                        r_ud   <= i_req.d;
                        r_neg  <= (i_req.a < 0) != (i_req.b < 0);
                        r_dz   <= i_req.d <= 0;
                        r_prod <= '0;
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_ovf  <= 1'b0;
                        r_cnt  <= '0;
                        r_st   <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_prod <= r_prod + pp_sh;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_cnt <= '0;
                        r_st  <= MD_DIV;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                MD_DIV: begin
                    r_rem  <= ge ? 64'(rem2 - {1'b0, r_ud}) : rem2[63:0];
                    r_q    <= {r_q[62:0], ge};
                    r_ovf  <= r_ovf | r_q[63];
                    r_prod <= {r_prod[126:0], 1'b0};
                    if (r_cnt == 7'd127) begin
                        r_st <= MD_RND;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                MD_RND: begin
                    if (r_dz) begin
                        r_res <= '0;
                    end else begin
                        r_res <= r_neg ? -$signed(magn) : $signed(magn);
                    end
                    r_st <= MD_DONE;
                end
                MD_DONE: begin
                    r_st <= MD_IDLE;
                end
                default: begin
                    r_st <= MD_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_st == MD_DONE);
    assign o_rsp.q    = r_res;

endmodule

`default_nettype wire

// File: rtl/npf_points.sv
// Point store of the fit unit: x and y memories, count and running statistics.
// Uses npf_pkg for the statistics struct.
`default_nettype none

module npf_points
    import npf_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire logic [15:0]                       i_x,
    input  wire logic [15:0]                       i_y,
    input  wire logic                              i_clr,
    input  wire logic [$clog2(MAX_POINTS)-1:0]     i_raddr,
    output logic [15:0]                            o_rx,
    output logic [15:0]                            o_ry,
    output logic [$clog2(MAX_POINTS+1)-1:0]        o_count,
    output t_pt_stats                              o_stats
);

    localparam int PA  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);

    logic [15:0]    r_mem_x [MAX_POINTS];
    logic [15:0]    r_mem_y [MAX_POINTS];
    logic [PCW-1:0] r_count;
    t_pt_stats      r_stats;
    logic           wr;

    // Points beyond the capacity are dropped.
    assign wr = i_push && (r_count != PCW'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem_x[r_count[PA-1:0]] <= i_x;
            r_mem_y[r_count[PA-1:0]] <= i_y;
        end
        o_rx <= r_mem_x[i_raddr];
        o_ry <= r_mem_y[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_count <= '0;
            r_stats <= '0;
        end else if (wr) begin
            r_count    <= r_count + 1'b1;
            r_stats.sx <= r_stats.sx + SUM_W'(i_x);
            r_stats.sy <= r_stats.sy + SUM_W'(i_y);
            if (r_count == '0 || i_x < r_stats.xmin) begin
                r_stats.xmin <= i_x;
            end
            if (r_count == '0 || i_x > r_stats.xmax) begin
                r_stats.xmax <= i_x;
            end
        end
    end

    assign o_count = r_count;
    assign o_stats = r_stats;

endmodule

`default_nettype wire

// File: rtl/normalized_polynomial_lsq_fit_unit.sv
// Top level of the normalized polynomial least-squares fit unit.
// Depends on npf_pkg, npf_points and npf_muldiv.
//
// Points load one per cycle; the point with tlast set closes the set. The unit then
// counts distinct x values, clears the matrix and right-hand side of its workspace and
// runs every arithmetic step of the fit through one shared multiply-divide unit: each
// step fetches its operands from the workspace memory or as immediates, then takes
// 4 partial products, 128 division steps, rounding, hand-back and write-back. A set of n
// points at m = degree+1 coefficients needs n*(m*m+2*m+1) steps for the normal
// equations, about m*m*m/3 for elimination, m*m/2 for back substitution and m for
// the outputs. Coefficients leave lowest power first; the unit accepts no point
// until the last is taken.
`default_nettype none

module normalized_polynomial_lsq_fit_unit
    import npf_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int MAX_DEGREE = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,   // fit_degree
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,    // [15:0] point_x, [31:16] point_y
    input  wire logic        s_axis_tlast,    // final_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,    // [31:0] coefficient
    output logic [3:0]       m_axis_tuser,    // [2:0] power_index, [3] fit_error
    output logic             m_axis_tlast     // last_coefficient
);

    localparam int NC       = MAX_DEGREE + 1;
    localparam int CW       = $clog2(NC);
    localparam int PA       = $clog2(MAX_POINTS);
    localparam int PCW      = $clog2(MAX_POINTS + 1);
    localparam int WS_DEPTH = NC * NC + 3 * NC;
    localparam int WA       = $clog2(WS_DEPTH);
    localparam int B_OFS    = NC * NC;
    localparam int C_OFS    = NC * NC + NC;
    localparam int P_OFS    = NC * NC + 2 * NC;
    localparam int CLR_LAST = NC * NC + NC - 1;

    typedef enum logic [10:0] {
        S_LOAD   = 11'b000_0000_0001,
        S_SCAN_I = 11'b000_0000_0010,
        S_SCAN_X = 11'b000_0000_0100,
        S_SCAN_C = 11'b000_0000_1000,
        S_CLR    = 11'b000_0001_0000,
        S_PT_RD  = 11'b000_0010_0000,
        S_PT_CAP = 11'b000_0100_0000,
        S_FETCH  = 11'b000_1000_0000,
        S_MD     = 11'b001_0000_0000,
        S_WB     = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    typedef enum logic [3:0] {
        P_U, P_V, P_PW, P_AJK, P_BJ, P_EA, P_EB, P_BS, P_BC, P_OUT
    } t_phase;

    typedef enum logic [2:0] {
        D_MEM, D_U, D_V, D_S, D_OUT
    } t_dest;

    t_state             r_state;
    t_phase             r_phase;
    logic [2:0]         r_cfg;
    logic [CW-1:0]      r_mlast, r_j, r_k, r_r;
    logic [PA-1:0]      r_i, r_pj;
    logic [PCW-1:0]     r_dist;
    logic               r_seen, r_err;
    logic [15:0]        r_xi;
    logic [2:0]         r_fcnt;
    logic [WA-1:0]      r_clr;
    logic signed [63:0] r_op [4];
    logic signed [63:0] r_u, r_v, r_s, r_ax, r_ay;
    logic signed [31:0] r_coef;
    logic [2:0]         r_pidx;
    logic               r_last;
    logic signed [63:0] r_ws [WS_DEPTH];
    logic signed [63:0] r_ws_rd;

    // Point store
    logic               in_acc;
    logic               pt_clr;
    logic [PA-1:0]      pt_raddr;
    logic [15:0]        pt_rx, pt_ry;
    logic [PCW-1:0]     pt_count;
    t_pt_stats          pt_stats;

    // Operand descriptor of the current step
    logic               s_mem  [4];
    logic [WA-1:0]      s_addr [4];
    logic signed [63:0] s_imm  [4];
    t_dest              d_kind;
    logic [WA-1:0]      d_addr;
    logic               d_neg;

    t_md_req            md_req;
    t_md_rsp            md_rsp;

    logic [2:0]         deg_c;
    logic [PCW-1:0]     cnt_m1;
    logic               i_last;
    logic               match;
    logic [PCW-1:0]     dist_n;
    logic [PCW+15:0]    nx, ny, nr;
    logic signed [63:0] nr64;
    logic [1:0]         cap_idx;
    logic [WA-1:0]      ws_raddr;
    logic               ws_we;
    logic [WA-1:0]      ws_waddr;
    logic signed [63:0] ws_wdata;
    logic signed [63:0] qv, addend, sum, sum_sat;
    logic signed [31:0] coef32;

    function automatic logic [WA-1:0] a_at(input logic [CW-1:0] row, input logic [CW-1:0] col);
        return WA'(row) * WA'(NC) + WA'(col);
    endfunction

    function automatic logic [WA-1:0] ofs_at(input int base, input logic [CW-1:0] idx);
        return WA'(base) + WA'(idx);
    endfunction

    npf_points #(
        .MAX_POINTS (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .i_clr   (pt_clr),
        .i_raddr (pt_raddr),
        .o_rx    (pt_rx),
        .o_ry    (pt_ry),
        .o_count (pt_count),
        .o_stats (pt_stats)
    );

    npf_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pt_clr        = (r_state == S_EMIT) && m_axis_tready && (r_k == r_mlast);

    always_comb begin
        if (r_cfg == 3'd0) begin
            deg_c = 3'd1;
        end else if (r_cfg > MAX_DEGREE) begin
            deg_c = 3'(MAX_DEGREE);
        end else begin
            deg_c = r_cfg;
        end
    end

    assign cnt_m1 = pt_count - 1'b1;
    assign i_last = (r_i == cnt_m1[PA-1:0]);
    assign match  = (pt_rx == r_xi);
    assign dist_n = (r_state == S_SCAN_X) ? r_dist + 1'b1
                                          : r_dist + PCW'(!(r_seen || match));

    always_comb begin
        unique case (r_state)
            S_SCAN_X: pt_raddr = '0;
            S_SCAN_C: pt_raddr = r_pj + 1'b1;
            default:  pt_raddr = r_i;
        endcase
    end

    assign nx   = (PCW+16)'(pt_count) * (PCW+16)'(pt_rx);
    assign ny   = (PCW+16)'(pt_count) * (PCW+16)'(pt_ry);
    assign nr   = (PCW+16)'(pt_count) * (PCW+16)'(pt_stats.xmax - pt_stats.xmin);
    assign nr64 = $signed(64'(nr));

    // Operand slots: 0 = multiplicand, 1 = multiplier, 2 = divisor, 3 = accumulator base.
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            s_mem[n]  = 1'b0;
            s_addr[n] = '0;
            s_imm[n]  = '0;
        end
        d_kind = D_MEM;
        d_addr = '0;
        d_neg  = 1'b0;
        case (r_phase)
            P_U, P_V: begin
                s_imm[0] = (r_phase == P_U) ? r_ax : r_ay;
                s_imm[1] = ONE_Q30;
                s_imm[2] = nr64;
                d_kind   = (r_phase == P_U) ? D_U : D_V;
            end
            P_PW: begin
                s_mem[0]  = (r_k != CW'(1));
                s_addr[0] = ofs_at(P_OFS, r_k - 1'b1);
                s_imm[0]  = ONE_Q30;
                s_imm[1]  = r_u;
                s_imm[2]  = ONE_Q30;
                d_addr    = ofs_at(P_OFS, r_k);
            end
            P_AJK, P_BJ: begin
                // The zeroth power is the constant one and is never stored.
                s_mem[0]  = (r_j != '0);
                s_addr[0] = ofs_at(P_OFS, r_j);
                s_imm[0]  = ONE_Q30;
                s_imm[2]  = ONE_Q30;
                s_mem[3]  = 1'b1;
                if (r_phase == P_AJK) begin
                    s_mem[1]  = (r_k != '0);
                    s_addr[1] = ofs_at(P_OFS, r_k);
                    s_imm[1]  = ONE_Q30;
                    s_addr[3] = a_at(r_j, r_k);
                end else begin
                    s_imm[1]  = r_v;
                    s_addr[3] = ofs_at(B_OFS, r_j);
                end
                d_addr = s_addr[3];
            end
            P_EA, P_EB: begin
                s_mem[0]  = 1'b1;
                s_addr[0] = a_at(r_r, r_k);
                s_mem[1]  = 1'b1;
                s_addr[1] = (r_phase == P_EA) ? a_at(r_k, r_j) : ofs_at(B_OFS, r_k);
                s_mem[2]  = 1'b1;
                s_addr[2] = a_at(r_k, r_k);
                s_mem[3]  = 1'b1;
                s_addr[3] = (r_phase == P_EA) ? a_at(r_r, r_j) : ofs_at(B_OFS, r_r);
                d_addr    = s_addr[3];
                d_neg     = 1'b1;
            end
            P_BS: begin
                s_mem[0]  = 1'b1;
                s_addr[0] = a_at(r_k, r_j);
                s_mem[1]  = 1'b1;
                s_addr[1] = ofs_at(C_OFS, r_j);
                s_imm[2]  = ONE_Q30;
                // The running sum starts from the right-hand side entry of the row.
                s_mem[3]  = ({1'b0, r_j} == {1'b0, r_k} + 1'b1);
                s_addr[3] = ofs_at(B_OFS, r_k);
                s_imm[3]  = r_s;
                d_kind    = D_S;
                d_neg     = 1'b1;
            end
            P_BC: begin
                s_mem[0]  = (r_k == r_mlast);
                s_addr[0] = ofs_at(B_OFS, r_k);
                s_imm[0]  = r_s;
                s_imm[1]  = ONE_Q30;
                s_mem[2]  = 1'b1;
                s_addr[2] = a_at(r_k, r_k);
                d_addr    = ofs_at(C_OFS, r_k);
            end
            P_OUT: begin
                s_mem[0]  = 1'b1;
                s_addr[0] = ofs_at(C_OFS, r_k);
                s_imm[1]  = IMM_ONE;
                s_imm[2]  = ONE_Q14;
                d_kind    = D_OUT;
            end
            default: begin
                d_kind = D_MEM;
            end
        endcase
    end

    assign cap_idx  = 2'(r_fcnt - 3'd1);
    assign ws_raddr = s_addr[r_fcnt[1:0]];

    assign md_req.start = (r_state == S_FETCH) && (r_fcnt == 3'd4);
    assign md_req.a     = r_op[0];
    assign md_req.b     = r_op[1];
    assign md_req.d     = r_op[2];

    assign qv      = md_rsp.q;
    assign addend  = d_neg ? -qv : qv;
    assign sum     = r_op[3] + addend;
    assign sum_sat = (sum > SAT_LIM) ? SAT_LIM : ((sum < -SAT_LIM) ? -SAT_LIM : sum);

    always_comb begin
        if (qv > 64'sh0000_0000_7FFF_FFFF) begin
            coef32 = 32'sh7FFF_FFFF;
        end else if (qv < -64'sh0000_0000_8000_0000) begin
            coef32 = 32'sh8000_0000;
        end else begin
            coef32 = qv[31:0];
        end
    end

    assign ws_we    = (r_state == S_CLR) || ((r_state == S_WB) && (d_kind == D_MEM));
    assign ws_waddr = (r_state == S_CLR) ? r_clr : d_addr;
    assign ws_wdata = (r_state == S_CLR) ? '0 : sum_sat;

    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            r_ws[ws_waddr] <= ws_wdata;
        end
        r_ws_rd <= r_ws[ws_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 3'd2;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_phase <= P_U;
            r_err   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_r     <= '0;
            r_pj    <= '0;
            r_dist  <= '0;
            r_seen  <= 1'b0;
            r_fcnt  <= '0;
            r_clr   <= '0;
            r_mlast <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc && s_axis_tlast) begin
                        r_mlast <= CW'(deg_c);
                        r_err   <= 1'b0;
                        r_dist  <= '0;
                        r_i     <= '0;
                        r_state <= S_SCAN_I;
                    end
                end
                S_SCAN_I: begin
                    r_state <= S_SCAN_X;
                end
                S_SCAN_X, S_SCAN_C: begin
                    if (r_state == S_SCAN_X) begin
                        r_xi   <= pt_rx;
                        r_pj   <= '0;
                        r_seen <= 1'b0;
                    end else begin
                        r_seen <= r_seen || match;
                        r_pj   <= r_pj + 1'b1;
                    end
                    if ((r_state == S_SCAN_X && r_i == '0) ||
                        (r_state == S_SCAN_C && r_pj == r_i - 1'b1)) begin
                        r_dist <= dist_n;
                        if (!i_last) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_SCAN_I;
                        end else if (dist_n <= r_mlast) begin
                            // Too few distinct x values: zero coefficients with error.
                            r_err   <= 1'b1;
                            r_phase <= P_OUT;
                            r_k     <= '0;
                            r_fcnt  <= '0;
                            r_state <= S_FETCH;
                        end else begin
                            r_i     <= '0;
                            r_clr   <= '0;
                            r_state <= S_CLR;
                        end
                    end else if (r_state == S_SCAN_X) begin
                        r_state <= S_SCAN_C;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WA'(CLR_LAST)) begin
                        r_state <= S_PT_RD;
                    end
                end
                S_PT_RD: begin
                    r_state <= S_PT_CAP;
                end
                S_PT_CAP: begin
                    r_ax    <= $signed(64'(nx)) - $signed(64'(pt_stats.sx));
                    r_ay    <= $signed(64'(ny)) - $signed(64'(pt_stats.sy));
                    r_phase <= P_U;
                    r_fcnt  <= '0;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    if (r_fcnt != 3'd0) begin
                        r_op[cap_idx] <= s_mem[cap_idx] ? r_ws_rd : s_imm[cap_idx];
                    end
                    // Every divisor read from the matrix is a pivot.
                    if (r_fcnt == 3'd3 && s_mem[2] && r_ws_rd <= 0) begin
                        r_err <= 1'b1;
                    end
                    if (r_fcnt == 3'd4) begin
                        r_state <= S_MD;
                    end else begin
                        r_fcnt <= r_fcnt + 3'd1;
                    end
                end
                S_MD: begin
                    if (md_rsp.done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_fcnt <= '0;
                    if (r_phase == P_OUT) begin
                        r_state <= S_EMIT;
                    end else if (r_phase == P_BJ && r_j == r_mlast && !i_last) begin
                        r_state <= S_PT_RD;
                    end else begin
                        r_state <= S_FETCH;
                    end
                    case (d_kind)
                        D_U:     r_u <= sum_sat;
                        D_V:     r_v <= sum_sat;
                        D_S:     r_s <= sum_sat;
                        default: r_s <= r_s;
                    endcase
                    case (r_phase)
                        P_U: begin
                            r_phase <= P_V;
                        end
                        P_V: begin
                            r_k     <= CW'(1);
                            r_phase <= P_PW;
                        end
                        P_PW: begin
                            if (r_k == r_mlast) begin
                                r_j     <= '0;
                                r_k     <= '0;
                                r_phase <= P_AJK;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                        P_AJK: begin
                            if (r_k != r_mlast) begin
                                r_k <= r_k + 1'b1;
                            end else if (r_j != r_mlast) begin
                                r_j <= r_j + 1'b1;
                                r_k <= '0;
                            end else begin
                                r_j     <= '0;
                                r_phase <= P_BJ;
                            end
                        end
                        P_BJ: begin
                            if (r_j != r_mlast) begin
                                r_j <= r_j + 1'b1;
                            end else if (!i_last) begin
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_k     <= '0;
                                r_r     <= CW'(1);
                                r_j     <= CW'(1);
                                r_phase <= P_EA;
                            end
                        end
                        P_EA: begin
                            if (r_j == r_mlast) begin
                                r_phase <= P_EB;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                        P_EB: begin
                            if (r_r != r_mlast) begin
                                r_r     <= r_r + 1'b1;
                                r_j     <= r_k + 1'b1;
                                r_phase <= P_EA;
                            end else if (r_k + 1'b1 == r_mlast) begin
                                r_k     <= r_mlast;
                                r_phase <= P_BC;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_r     <= r_k + CW'(2);
                                r_j     <= r_k + CW'(2);
                                r_phase <= P_EA;
                            end
                        end
                        P_BS: begin
                            if (r_j == r_mlast) begin
                                r_phase <= P_BC;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end
                        P_BC: begin
                            if (r_k == '0) begin
                                r_phase <= P_OUT;
                            end else begin
                                r_k     <= r_k - 1'b1;
                                r_j     <= r_k;
                                r_phase <= P_BS;
                            end
                        end
                        P_OUT: begin
                            r_coef <= r_err ? 32'sd0 : coef32;
                            r_pidx <= 3'(r_k);
                            r_last <= (r_k == r_mlast);
                        end
                        default: begin
                            r_phase <= P_OUT;
                        end
                    endcase
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        if (r_k == r_mlast) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_fcnt  <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_EMIT);
    assign m_axis_tdata  = r_coef;
    assign m_axis_tuser  = {r_err, r_pidx};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// File: rtl/npf_checker.sv
// Port-level checker for the polynomial fit unit, bound to the top level.
// Depends on the assertion macros in normalized_polynomial_lsq_fit_unit_defines.svh.
`default_nettype none

`include "normalized_polynomial_lsq_fit_unit_defines.svh"

module npf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // While coefficients are pending no new point is taken.
    `NPF_ASSERT_SAME(a_no_load_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)

    // A failed fit reports zero coefficients.
    `NPF_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3],
                     m_axis_tdata == 32'd0)

    // A stalled coefficient transaction holds its value.
    `NPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // The last coefficient ends the run and the block returns to loading.
    `NPF_ASSERT_NEXT(a_run_end, i_clk, i_rst_n,
                     m_axis_tvalid && m_axis_tready && m_axis_tlast,
                     !m_axis_tvalid && s_axis_tready)

    // A point that does not close the set leaves the input open.
    `NPF_ASSERT_NEXT(a_load_open, i_clk, i_rst_n,
                     s_axis_tvalid && s_axis_tready && !s_axis_tlast, s_axis_tready)

endmodule

bind normalized_polynomial_lsq_fit_unit npf_checker u_npf_checker (.*);

`default_nettype wire
